/* rtl/core/chm_pkg.sv */
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the chained hash map: request and response
// structs, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int BUCKETS_DEF    = 251;
	localparam int POOL_NODES_DEF = 256;

	localparam int OP_W    = 2;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 9;
	localparam int DIGIT_W = 4;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_HEAD,
		ST_WALK,
		ST_LINK,
		ST_LINK2,
		ST_REM,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  found_value;
		logic [CNT_W-1:0]  entry_count;
	} rsp_t;

endpackage

/* rtl/core/chm_ram.sv */
// ----------------------------------------------------------------------------
// chm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/chm_mod.sv */
// ----------------------------------------------------------------------------
// chm_mod
// Iterative key modulo BUCKETS on one shared multiplier: reciprocal multiply
// for the quotient, back-multiply by BUCKETS, then subtract.
// ----------------------------------------------------------------------------
module chm_mod #(
	parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
	localparam int BW = $clog2(BUCKETS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [chm_pkg::KEY_W-1:0] key,
	output logic                     done,
	output logic [BW-1:0]            rem
);

	localparam int KW = chm_pkg::KEY_W;
	localparam int MW = KW + 1;
	localparam int PW = 2 * MW;
	localparam int SH = KW + BW;
	localparam logic [63:0] RECIP_W =
		((64'd1 << SH) + 64'(BUCKETS - 1)) / 64'(BUCKETS);
	localparam logic [MW-1:0] RECIP = RECIP_W[MW-1:0];
	localparam logic [MW-1:0] DIV   = MW'(BUCKETS);
	localparam logic [1:0]    LAST  = 2'd2;

	logic          busy_q;
	logic          done_q;
	logic [1:0]    cnt_q;
	logic [BW-1:0] rem_q;
	logic [KW-1:0] key_q;
	logic [PW-1:0] prod_q;
	logic [MW-1:0] mul_a;
	logic [MW-1:0] mul_b;
	logic [PW-1:0] prod;
	logic [KW-1:0] diff;

	// step 0: key * reciprocal, step 1: quotient * BUCKETS, step 2: subtract
	always_comb begin
		if (cnt_q == 2'd0) begin
			mul_a = {1'b0, key_q};
			mul_b = RECIP;
		end else begin
			mul_a = MW'(prod_q >> SH);
			mul_b = DIV;
		end
		prod = mul_a * mul_b;
		diff = key_q - prod_q[KW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end else if (busy_q) begin
			prod_q <= prod;
			if (cnt_q == LAST) begin
				rem_q <= diff[BW-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* rtl/core/chained_hash_map_top.sv */
// ----------------------------------------------------------------------------
// chained_hash_map_top
// Key-value map with separate chaining: buckets by key modulo BUCKETS,
// chain nodes from a fixed pool managed through a free list.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req (req_valid / req_stall): operation, key, value.
//   Response channel rsp (rsp_valid / rsp_stall): status, found_value,
//   entry_count. One response per request, in order.
//   One request is processed at a time; req_stall stays high while it runs.
//   Per transaction the sequencer computes the bucket index in the shared
//   multiply unit, reads the bucket head, reads node memory once per chain
//   node visited, updates links in up to two link-update states and loads
//   the response register. It returns to idle before the next accept, so a
//   new request is taken only after the previous one is through.
//   A new request is taken while the previous response still waits.
//   After reset a clearing pass over max(BUCKETS, POOL_NODES) entries empties
//   the bucket heads and chains all pool nodes into the free list; no
//   request is accepted during that pass.
//   A stalled response holds in the output register; the sequencer waits
//   in its final state until the register is free.
// ----------------------------------------------------------------------------
module chained_hash_map_top #(
	parameter int BUCKETS    = chm_pkg::BUCKETS_DEF,
	parameter int POOL_NODES = chm_pkg::POOL_NODES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  chm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output chm_pkg::rsp_t rsp
);

	localparam int BW    = $clog2(BUCKETS);
	localparam int PW    = $clog2(POOL_NODES);
	localparam int NW    = $clog2(POOL_NODES + 1);
	localparam int CLR_N = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
	localparam int CW    = $clog2(CLR_N);
	localparam logic [NW-1:0] NULL_NODE = NW'(POOL_NODES);

	function automatic logic [NW-1:0] link_of(input logic [NW-1:0] x);
		return (x >= NULL_NODE) ? NULL_NODE : x;
	endfunction

	chm_pkg::state_t state_q, state_d;
	logic [CW-1:0]   idx_q, idx_d;
	logic [NW-1:0]   free_q, free_d;
	logic [NW-1:0]   count_q, count_d;
	logic            rsp_valid_q, rsp_valid_d;

	logic [chm_pkg::OP_W-1:0]   op_q, op_d;
	logic [chm_pkg::KEY_W-1:0]  key_q, key_d;
	logic [chm_pkg::VAL_W-1:0]  val_q, val_d;
	logic [BW-1:0]              bucket_q, bucket_d;
	logic [NW-1:0]              cur_q, cur_d;
	logic [NW-1:0]              prev_q, prev_d;
	logic [chm_pkg::STAT_W-1:0] status_q, status_d;
	logic [chm_pkg::VAL_W-1:0]  found_q, found_d;
	chm_pkg::rsp_t              rsp_q, rsp_d;

	logic          mod_start;
	logic          mod_done;
	logic [BW-1:0] mod_rem;

	logic                      head_we;
	logic [BW-1:0]             head_waddr;
	logic [NW-1:0]             head_wdata;
	logic [NW-1:0]             head_rdata;
	logic                      node_we;
	logic [PW-1:0]             node_waddr;
	logic [PW-1:0]             node_raddr;
	logic [chm_pkg::KEY_W-1:0] key_rdata;
	logic [chm_pkg::VAL_W-1:0] val_rdata;
	logic                      next_we;
	logic [PW-1:0]             next_waddr;
	logic [NW-1:0]             next_wdata;
	logic [NW-1:0]             next_rdata;

	logic          accept;
	logic          miss;
	logic [NW-1:0] head_node;
	logic [NW-1:0] next_node;

	chm_mod #(.BUCKETS(BUCKETS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.key    (key_d),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	chm_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (mod_rem),
		.rdata (head_rdata)
	);

	chm_ram #(.WIDTH(chm_pkg::KEY_W), .DEPTH(POOL_NODES)) u_key_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (key_q),
		.raddr (node_raddr),
		.rdata (key_rdata)
	);

	chm_ram #(.WIDTH(chm_pkg::VAL_W), .DEPTH(POOL_NODES)) u_val_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (val_q),
		.raddr (node_raddr),
		.rdata (val_rdata)
	);

	chm_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.raddr (node_raddr),
		.rdata (next_rdata)
	);

	assign head_node = link_of(head_rdata);
	assign next_node = link_of(next_rdata);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		free_d      = free_q;
		count_d     = count_q;
		rsp_valid_d = rsp_valid_q;
		op_d        = op_q;
		key_d       = key_q;
		val_d       = val_q;
		bucket_d    = bucket_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		status_d    = status_q;
		found_d     = found_q;
		rsp_d       = rsp_q;

		req_stall  = (state_q != chm_pkg::ST_IDLE);
		accept     = req_valid && !req_stall;
		mod_start  = 1'b0;
		miss       = 1'b0;
		head_we    = 1'b0;
		head_waddr = bucket_q;
		head_wdata = NULL_NODE;
		node_we    = 1'b0;
		node_waddr = free_q[PW-1:0];
		node_raddr = cur_q[PW-1:0];
		next_we    = 1'b0;
		next_waddr = cur_q[PW-1:0];
		next_wdata = NULL_NODE;

		if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end

		case (state_q)
			chm_pkg::ST_CLEAR: begin
				head_we    = int'(idx_q) < BUCKETS;
				head_waddr = BW'(idx_q);
				head_wdata = NULL_NODE;
				next_we    = int'(idx_q) < POOL_NODES;
				next_waddr = PW'(idx_q);
				next_wdata = NW'(idx_q) + NW'(1);
				if (int'(idx_q) == CLR_N - 1) begin
					state_d = chm_pkg::ST_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			chm_pkg::ST_IDLE: begin
				if (accept) begin
					op_d     = req.operation;
					key_d    = req.key;
					val_d    = req.value;
					found_d  = '0;
					status_d = chm_pkg::STAT_MISS;
					case (req.operation)
						chm_pkg::OP_INSERT,
						chm_pkg::OP_FIND,
						chm_pkg::OP_REMOVE: begin
							mod_start = 1'b1;
							state_d   = chm_pkg::ST_MOD;
						end
						default: begin
							state_d = chm_pkg::ST_FIN;
						end
					endcase
				end
			end
			chm_pkg::ST_MOD: begin
				if (mod_done) begin
					bucket_d = mod_rem;
					prev_d   = NULL_NODE;
					state_d  = chm_pkg::ST_HEAD;
				end
			end
			chm_pkg::ST_HEAD: begin
				if (head_node == NULL_NODE) begin
					miss = 1'b1;
				end else begin
					node_raddr = head_node[PW-1:0];
					cur_d      = head_node;
					state_d    = chm_pkg::ST_WALK;
				end
			end
			chm_pkg::ST_WALK: begin
				if (key_rdata == key_q) begin
					case (op_q)
						chm_pkg::OP_FIND: begin
							status_d = chm_pkg::STAT_OK;
							found_d  = val_rdata;
							state_d  = chm_pkg::ST_FIN;
						end
						chm_pkg::OP_REMOVE: begin
							if (prev_q == NULL_NODE) begin
								head_we    = 1'b1;
								head_wdata = next_node;
							end else begin
								next_we    = 1'b1;
								next_waddr = prev_q[PW-1:0];
								next_wdata = next_node;
							end
							state_d = chm_pkg::ST_REM;
						end
						default: begin
							status_d = chm_pkg::STAT_MISS;
							state_d  = chm_pkg::ST_FIN;
						end
					endcase
				end else begin
					prev_d = cur_q;
					if (next_node == NULL_NODE) begin
						miss = 1'b1;
					end else begin
						node_raddr = next_node[PW-1:0];
						cur_d      = next_node;
					end
				end
			end
			chm_pkg::ST_LINK: begin
				node_we    = 1'b1;
				node_waddr = free_q[PW-1:0];
				next_we    = 1'b1;
				next_waddr = free_q[PW-1:0];
				next_wdata = NULL_NODE;
				free_d     = next_node;
				cur_d      = free_q;
				count_d    = count_q + 1'b1;
				status_d   = chm_pkg::STAT_OK;
				if (prev_q == NULL_NODE) begin
					head_we    = 1'b1;
					head_wdata = free_q;
					state_d    = chm_pkg::ST_FIN;
				end else begin
					state_d = chm_pkg::ST_LINK2;
				end
			end
			chm_pkg::ST_LINK2: begin
				next_we    = 1'b1;
				next_waddr = prev_q[PW-1:0];
				next_wdata = cur_q;
				state_d    = chm_pkg::ST_FIN;
			end
			chm_pkg::ST_REM: begin
				next_we    = 1'b1;
				next_waddr = cur_q[PW-1:0];
				next_wdata = free_q;
				free_d     = cur_q;
				if (count_q != '0) begin
					count_d = count_q - 1'b1;
				end
				status_d = chm_pkg::STAT_OK;
				state_d  = chm_pkg::ST_FIN;
			end
			chm_pkg::ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_d.status      = status_q;
					rsp_d.found_value = found_q;
					rsp_d.entry_count = chm_pkg::CNT_W'(count_q);
					rsp_valid_d       = 1'b1;
					state_d           = chm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = chm_pkg::ST_IDLE;
			end
		endcase

		// end of chain without a match
		if (miss) begin
			if (op_q == chm_pkg::OP_INSERT) begin
				if (free_q == NULL_NODE) begin
					status_d = chm_pkg::STAT_FULL;
					state_d  = chm_pkg::ST_FIN;
				end else begin
					node_raddr = free_q[PW-1:0];
					state_d    = chm_pkg::ST_LINK;
				end
			end else begin
				status_d = chm_pkg::STAT_MISS;
				state_d  = chm_pkg::ST_FIN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chm_pkg::ST_CLEAR;
			idx_q       <= '0;
			free_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			free_q      <= free_d;
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		key_q    <= key_d;
		val_q    <= val_d;
		bucket_q <= bucket_d;
		cur_q    <= cur_d;
		prev_q   <= prev_d;
		status_q <= status_d;
		found_q  <= found_d;
		rsp_q    <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
